### rtl/core/tdwc_pkg.sv
`timescale 1ns / 1ps
package tdwc_pkg;

  localparam int NODES      = 1024;
  localparam int ALPHABET   = 26;
  localparam int NODE_W     = $clog2(NODES);
  localparam int FREE_W     = $clog2(NODES + 1);
  localparam int SLOT_DEPTH = NODES * ALPHABET;
  localparam int SLOT_W     = $clog2(SLOT_DEPTH);
  localparam int LETTER_W   = $clog2(ALPHABET);
  localparam int COUNT_W    = 32;

  localparam logic [1:0] OP_LOAD_CHAR = 2'd0;
  localparam logic [1:0] OP_LOAD_END  = 2'd1;
  localparam logic [1:0] OP_SCAN_CHAR = 2'd2;
  localparam logic [1:0] OP_FLUSH     = 2'd3;

  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] hit_words;
    logic [COUNT_W-1:0] total_words;
    logic               word_done;
    logic               word_matched;
    logic               insert_dropped;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
  } ctrl_sts_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_dropped(input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    case (c)
      8'h2E, 8'h2C, 8'h21, 8'h23, 8'h26, 8'h28, 8'h29, 8'h27, 8'h22, 8'h3A,
      8'h3B, 8'h3C, 8'h3E, 8'h3F, 8'h2F, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h5C:
        hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= CH_LOWER_A) && (c <= CH_LOWER_Z);
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ? (c + CASE_DELTA) : c;
  endfunction

endpackage

### rtl/core/trie_dictionary_word_counter_top.sv
`timescale 1ns / 1ps
// Dictionary word counter over a lowercase a-z trie. After reset the block
// runs a clearing pass over all 26624 child-table slots (one slot per cycle,
// the word-end flags cleared alongside) with busy high. After that, a request
// is taken at a rising edge where start is high and busy is low. The accept
// edge fetches the child-table slot of the current node and letter together
// with the word-end flag of the scan node, and the following cycle evaluates
// the step, writes any new node or word mark and registers the result.
// out_valid is then high for exactly one cycle with out_item; busy is already
// low in that cycle, so a new request may be presented there. The receiver
// cannot stall and must take every result when out_valid is high. A new
// request is not taken before the last one is through, as set by the
// dependent read of the child table: each character needs the node found by
// the one before it.
module trie_dictionary_word_counter_top import tdwc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  // command and status between sequencer and datapath
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer: clearing pass, then accept / execute alternation
  tdwc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // datapath: trie memories, walk registers, counters, result register
  tdwc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

### rtl/core/tdwc_ram.sv
`timescale 1ns / 1ps
module tdwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/tdwc_ctrl.sv
`timescale 1ns / 1ps
module tdwc_ctrl import tdwc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  ctrl_sts_t  sts,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (sts.clear_done) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign cmd.clear  = (state_r == S_CLEAR);
  assign cmd.accept = (state_r == S_IDLE) && start;
  assign cmd.exec   = (state_r == S_EXEC);

endmodule

### rtl/core/tdwc_datapath.sv
`timescale 1ns / 1ps
module tdwc_datapath import tdwc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  ctrl_cmd_t  cmd,
  input  in_item_t   in_item,
  output ctrl_sts_t  sts,
  output logic       out_valid,
  output out_item_t  out_item
);

  // item and walk state
  in_item_t            item_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [NODE_W-1:0]   load_node_r, load_node_nxt;
  logic                load_bad_r, load_bad_nxt;
  logic [NODE_W-1:0]   scan_node_r, scan_node_nxt;
  logic                scan_miss_r, scan_miss_nxt;
  logic                in_token_r, in_token_nxt;
  logic [FREE_W-1:0]   next_free_r, next_free_nxt;
  logic [COUNT_W-1:0]  hit_r, hit_nxt;
  logic [COUNT_W-1:0]  word_r, word_nxt;
  logic [SLOT_W-1:0]   clr_cnt_r;
  logic                out_valid_r;
  out_item_t           out_item_r, out_item_nxt;

  // read address for the child fetch
  logic [7:0]          rd_char;
  logic [7:0]          rd_letter;
  logic [NODE_W-1:0]   rd_node;
  logic [SLOT_W-1:0]   rd_slot;

  // memory ports
  logic                child_we;
  logic [SLOT_W-1:0]   child_waddr;
  logic [NODE_W-1:0]   child_wdata;
  logic [NODE_W-1:0]   child_q;
  logic                flag_we;
  logic [NODE_W-1:0]   flag_waddr;
  logic                flag_wdata;
  logic                flag_q;

  logic                alloc;
  logic                mark;
  logic                end_tok;
  logic                hit;
  logic [7:0]          scan_c;

  assign rd_char   = fold_case(in_item.char_code);
  assign rd_letter = rd_char - CH_LOWER_A;
  assign rd_node   = (in_item.opcode == OP_LOAD_CHAR) ? load_node_r : scan_node_r;
  assign rd_slot   = SLOT_W'(rd_node) * SLOT_W'(ALPHABET)
                   + SLOT_W'(rd_letter[LETTER_W-1:0]);

  assign sts.clear_done = (clr_cnt_r == SLOT_W'(SLOT_DEPTH - 1));

  assign scan_c = fold_case(item_r.char_code);
  assign hit    = !scan_miss_r && flag_q;

  always_comb begin
    load_node_nxt = load_node_r;
    load_bad_nxt  = load_bad_r;
    scan_node_nxt = scan_node_r;
    scan_miss_nxt = scan_miss_r;
    in_token_nxt  = in_token_r;
    next_free_nxt = next_free_r;
    hit_nxt       = hit_r;
    word_nxt      = word_r;
    alloc         = 1'b0;
    mark          = 1'b0;
    end_tok       = 1'b0;
    out_item_nxt  = out_item_r;
    out_item_nxt.word_done      = 1'b0;
    out_item_nxt.word_matched   = 1'b0;
    out_item_nxt.insert_dropped = 1'b0;

    case (item_r.opcode)
      OP_LOAD_CHAR: begin
        if (!load_bad_r) begin
          if (!is_lower(item_r.char_code)) begin
            load_bad_nxt = 1'b1;
          end else if (child_q != '0) begin
            load_node_nxt = child_q;
          end else if (next_free_r == FREE_W'(NODES)) begin
            load_bad_nxt = 1'b1;
          end else begin
            alloc         = 1'b1;
            load_node_nxt = next_free_r[NODE_W-1:0];
            next_free_nxt = next_free_r + 1'b1;
          end
        end
      end
      OP_LOAD_END: begin
        out_item_nxt.insert_dropped = load_bad_r;
        mark          = !load_bad_r;
        load_node_nxt = '0;
        load_bad_nxt  = 1'b0;
      end
      OP_SCAN_CHAR: begin
        if (is_space(item_r.char_code)) begin
          end_tok = in_token_r;
        end else begin
          in_token_nxt = 1'b1;
          if (!is_dropped(item_r.char_code)) begin
            if (!is_lower(scan_c)) begin
              scan_miss_nxt = 1'b1;
            end else if (!scan_miss_r) begin
              if (child_q == '0) begin
                scan_miss_nxt = 1'b1;
              end else begin
                scan_node_nxt = child_q;
              end
            end
          end
        end
      end
      default: begin
        end_tok = in_token_r;
      end
    endcase

    if (end_tok) begin
      word_nxt = (word_r == '1) ? word_r : word_r + 1'b1;
      if (hit) begin
        hit_nxt = (hit_r == '1) ? hit_r : hit_r + 1'b1;
      end
      out_item_nxt.word_done    = 1'b1;
      out_item_nxt.word_matched = hit;
      scan_node_nxt = '0;
      scan_miss_nxt = 1'b0;
      in_token_nxt  = 1'b0;
    end

    out_item_nxt.hit_words   = hit_nxt;
    out_item_nxt.total_words = word_nxt;
  end

  // clearing pass owns the write ports while it runs
  assign child_we    = cmd.clear || (cmd.exec && alloc);
  assign child_waddr = cmd.clear ? clr_cnt_r : slot_r;
  assign child_wdata = cmd.clear ? '0 : next_free_r[NODE_W-1:0];

  assign flag_we    = (cmd.clear && (clr_cnt_r < SLOT_W'(NODES))) || (cmd.exec && mark);
  assign flag_waddr = cmd.clear ? clr_cnt_r[NODE_W-1:0] : load_node_r;
  assign flag_wdata = !cmd.clear;

  tdwc_ram #(
    .WIDTH (NODE_W),
    .DEPTH (SLOT_DEPTH)
  ) u_child_ram (
    .clk   (clk),
    .we    (child_we),
    .waddr (child_waddr),
    .wdata (child_wdata),
    .raddr (rd_slot),
    .rdata (child_q)
  );

  tdwc_ram #(
    .WIDTH (1),
    .DEPTH (NODES)
  ) u_flag_ram (
    .clk   (clk),
    .we    (flag_we),
    .waddr (flag_waddr),
    .wdata (flag_wdata),
    .raddr (scan_node_r),
    .rdata (flag_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_item;
      slot_r <= rd_slot;
    end
    if (cmd.exec) begin
      out_item_r <= out_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_node_r <= '0;
      load_bad_r  <= 1'b0;
      scan_node_r <= '0;
      scan_miss_r <= 1'b0;
      in_token_r  <= 1'b0;
      next_free_r <= FREE_W'(1);
      hit_r       <= '0;
      word_r      <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.exec;
      if (cmd.clear && !sts.clear_done) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.exec) begin
        load_node_r <= load_node_nxt;
        load_bad_r  <= load_bad_nxt;
        scan_node_r <= scan_node_nxt;
        scan_miss_r <= scan_miss_nxt;
        in_token_r  <= in_token_nxt;
        next_free_r <= next_free_nxt;
        hit_r       <= hit_nxt;
        word_r      <= word_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
